// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros included by the row generator top
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante implies cons");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante implies cons next cycle");

`endif

// ===== rtl/sgr_pkg.sv =====
// ---------------------------------------------------------------------------
// sgr_pkg
// Types, font table and helpers for the scaled glyph row generator.
// ---------------------------------------------------------------------------
`default_nettype none

package sgr_pkg;

   localparam int GLYPH_ROWS = 5;
   localparam int GLYPH_COLS = 3;
   localparam int NUM_GLYPHS = 36;

   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
   localparam logic [7:0] CHAR_LO_A   = 8'h61;
   localparam logic [7:0] CHAR_LO_Z   = 8'h7A;
   localparam logic [5:0] LETTER_BASE = 6'd10;

   typedef struct packed {
      logic [7:0] char_code;
      logic [9:0] rect_x;
      logic [9:0] rect_y;
      logic [9:0] rect_w;
      logic [9:0] rect_h;
      logic [7:0] attribute;
   } sgr_req_type;

   typedef struct packed {
      logic signed [11:0] row_y;
      logic signed [11:0] col_x;
      logic [8:0]         cell_mask;
      logic [7:0]         cell_attr;
      logic               last_row;
   } sgr_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_READ,
      ST_DRAIN
   } sgr_state_type;

   // bit 0 of a row is the leftmost column; digits first, then A..Z
   localparam logic [2:0] FONT_ROM [NUM_GLYPHS][GLYPH_ROWS] = '{
      '{3'd7,3'd5,3'd5,3'd5,3'd7}, '{3'd4,3'd4,3'd4,3'd4,3'd4},
      '{3'd7,3'd4,3'd7,3'd1,3'd7}, '{3'd7,3'd4,3'd7,3'd4,3'd7},
      '{3'd5,3'd5,3'd7,3'd4,3'd4}, '{3'd7,3'd1,3'd7,3'd4,3'd7},
      '{3'd7,3'd1,3'd7,3'd5,3'd7}, '{3'd7,3'd4,3'd4,3'd4,3'd4},
      '{3'd7,3'd5,3'd7,3'd5,3'd7}, '{3'd7,3'd5,3'd7,3'd4,3'd7},
      '{3'd2,3'd5,3'd7,3'd5,3'd5}, '{3'd3,3'd5,3'd3,3'd5,3'd3},
      '{3'd7,3'd1,3'd1,3'd1,3'd7}, '{3'd3,3'd5,3'd5,3'd5,3'd3},
      '{3'd7,3'd1,3'd3,3'd1,3'd7}, '{3'd7,3'd1,3'd3,3'd1,3'd1},
      '{3'd7,3'd1,3'd5,3'd5,3'd7}, '{3'd5,3'd5,3'd7,3'd5,3'd5},
      '{3'd7,3'd2,3'd2,3'd2,3'd7}, '{3'd4,3'd4,3'd4,3'd5,3'd7},
      '{3'd5,3'd5,3'd3,3'd5,3'd5}, '{3'd1,3'd1,3'd1,3'd1,3'd7},
      '{3'd7,3'd7,3'd5,3'd5,3'd5}, '{3'd3,3'd5,3'd5,3'd5,3'd5},
      '{3'd7,3'd5,3'd5,3'd5,3'd7}, '{3'd7,3'd5,3'd7,3'd1,3'd1},
      '{3'd7,3'd5,3'd5,3'd7,3'd4}, '{3'd7,3'd5,3'd3,3'd5,3'd5},
      '{3'd7,3'd1,3'd7,3'd4,3'd7}, '{3'd7,3'd2,3'd2,3'd2,3'd2},
      '{3'd5,3'd5,3'd5,3'd5,3'd7}, '{3'd5,3'd5,3'd5,3'd5,3'd2},
      '{3'd5,3'd5,3'd5,3'd7,3'd7}, '{3'd5,3'd5,3'd2,3'd5,3'd5},
      '{3'd5,3'd5,3'd2,3'd2,3'd2}, '{3'd7,3'd4,3'd2,3'd1,3'd7}
   };

   function automatic logic [2:0] font_row(input logic [5:0] idx, input logic [2:0] row);
      return FONT_ROM[idx][row];
   endfunction

   // stretch each font column to sx cells
   function automatic logic [8:0] expand_row(input logic [2:0] b, input logic [1:0] sx);
      logic [8:0] m;
      case (sx)
         2'd3:    m = {{3{b[2]}}, {3{b[1]}}, {3{b[0]}}};
         2'd2:    m = {3'b000, {2{b[2]}}, {2{b[1]}}, {2{b[0]}}};
         default: m = {6'b000000, b};
      endcase
      return m;
   endfunction

   // d / 2 rounded toward zero
   function automatic logic signed [11:0] half_tz(input logic signed [11:0] d);
      logic signed [11:0] t;
      t = d + $signed({11'd0, d[11]});
      return t >>> 1;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sgr_ram.sv =====
// ---------------------------------------------------------------------------
// sgr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sgr_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 5
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/scaled_glyph_row_generator_top.sv =====
// ---------------------------------------------------------------------------
// scaled_glyph_row_generator_top
// Draws one character as a list of scaled, centered glyph rows.
// ---------------------------------------------------------------------------
// Usage:
//   Present a character on req_item and pulse start while busy is low; the
//   transfer happens at that edge. Rows come back on rsp_item, one per cycle
//   marked by rsp_strobe, top row first, last_row set on the final one.
//   The receiver cannot stall; every strobed row must be taken as it comes.
// Timing:
//   A letter or digit first writes its 5 horizontally stretched font
//   rows into the row buffer RAM (one write port), then reads one row per
//   cycle for 5 or 10 scaled rows (one read port, registered read data).
//   The first row appears once all font rows are written; busy drops
//   after the last row, and a new character can then start.
//   A period returns its single row the cycle after the transfer and the
//   block is ready again at once. Empty rectangles and unknown codes
//   return nothing and leave the block ready.
// Reset:
//   Synchronous reset returns to idle and drops any row still pending.
// ---------------------------------------------------------------------------
`default_nettype none

module scaled_glyph_row_generator_top
   import sgr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire sgr_req_type req_item,
   output      logic        rsp_strobe,
   output      sgr_rsp_type rsp_item
);

   `include "assert_macros.svh"

   localparam int RAM_AW = $clog2(GLYPH_ROWS);

   sgr_state_type state_ff, state_in;

   logic [5:0]         gidx_ff,  gidx_in;
   logic [1:0]         sx_ff,    sx_in;
   logic               sy2_ff,   sy2_in;
   logic [3:0]         fh_ff,    fh_in;
   logic signed [11:0] ox_ff,    ox_in;
   logic signed [11:0] oy_ff,    oy_in;
   logic [7:0]         attr_ff,  attr_in;
   logic [3:0]         cnt_ff,   cnt_in;
   logic               out_vld_ff,  out_vld_in;
   logic signed [11:0] out_y_ff,    out_y_in;
   logic               out_last_ff, out_last_in;
   logic               out_dot_ff,  out_dot_in;

   logic accept;
   logic is_empty, is_dot, is_known;
   logic [5:0] acc_gidx;
   logic [1:0] acc_sx;
   logic       acc_sy2;
   logic [3:0] acc_fw, acc_fh;
   logic signed [11:0] acc_ox, acc_oy, dot_x, dot_y;
   logic fill_last, read_last;

   logic              ram_we, ram_re;
   logic [RAM_AW-1:0] ram_waddr, ram_raddr;
   logic [8:0]        ram_wdata, ram_rdata;

   // ---------------- decode of the incoming item ----------------
   assign accept   = start && (state_ff == ST_IDLE);
   assign is_empty = (req_item.rect_w == 10'd0) || (req_item.rect_h == 10'd0);
   assign is_dot   = (req_item.char_code == CHAR_DOT);

   always_comb begin
      is_known = 1'b1;
      acc_gidx = 6'd0;
      if (req_item.char_code >= CHAR_ZERO && req_item.char_code <= CHAR_NINE) begin
         acc_gidx = 6'(req_item.char_code - CHAR_ZERO);
      end else if (req_item.char_code >= CHAR_LO_A && req_item.char_code <= CHAR_LO_Z) begin
         acc_gidx = 6'(req_item.char_code - CHAR_LO_A) + LETTER_BASE;
      end else if (req_item.char_code >= CHAR_UP_A && req_item.char_code <= CHAR_UP_Z) begin
         acc_gidx = 6'(req_item.char_code - CHAR_UP_A) + LETTER_BASE;
      end else begin
         is_known = 1'b0;
      end
   end

   // scale factors: w/5 clamped to 1..3, h/6 clamped to 1..2
   always_comb begin
      if (req_item.rect_w >= 10'd15) begin
         acc_sx = 2'd3;
         acc_fw = 4'd9;
      end else if (req_item.rect_w >= 10'd10) begin
         acc_sx = 2'd2;
         acc_fw = 4'd6;
      end else begin
         acc_sx = 2'd1;
         acc_fw = 4'd3;
      end
      acc_sy2 = (req_item.rect_h >= 10'd12);
      acc_fh  = acc_sy2 ? 4'd10 : 4'd5;
   end

   assign acc_ox = $signed({2'b00, req_item.rect_x}) +
                   half_tz($signed({2'b00, req_item.rect_w}) - $signed({8'd0, acc_fw}));
   assign acc_oy = $signed({2'b00, req_item.rect_y}) +
                   half_tz($signed({2'b00, req_item.rect_h}) - $signed({8'd0, acc_fh}));
   assign dot_x  = $signed({2'b00, req_item.rect_x}) +
                   half_tz($signed({2'b00, req_item.rect_w}) - 12'sd2);
   assign dot_y  = $signed({2'b00, req_item.rect_y}) +
                   $signed({2'b00, req_item.rect_h}) - 12'sd2;

   assign fill_last = (cnt_ff == 4'(GLYPH_ROWS - 1));
   assign read_last = (cnt_ff == fh_ff - 4'd1);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !is_empty && !is_dot && is_known) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (fill_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (read_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------- state outputs ----------------
   always_comb begin
      busy   = 1'b1;
      ram_we = 1'b0;
      ram_re = 1'b0;
      unique case (state_ff)
         ST_IDLE:  busy   = 1'b0;
         ST_FILL:  ram_we = 1'b1;
         ST_READ:  ram_re = 1'b1;
         ST_DRAIN: busy   = 1'b1;
         default:  busy   = 1'b1;
      endcase
   end

   // write phase and read phase never overlap, so no forwarding is needed
   assign ram_waddr = cnt_ff[RAM_AW-1:0];
   assign ram_wdata = expand_row(font_row(gidx_ff, cnt_ff[RAM_AW-1:0]), sx_ff);
   assign ram_raddr = sy2_ff ? cnt_ff[RAM_AW:1] : cnt_ff[RAM_AW-1:0];

   // ---------------- datapath ----------------
   always_comb begin
      gidx_in     = gidx_ff;
      sx_in       = sx_ff;
      sy2_in      = sy2_ff;
      fh_in       = fh_ff;
      ox_in       = ox_ff;
      oy_in       = oy_ff;
      attr_in     = attr_ff;
      cnt_in      = cnt_ff;
      out_vld_in  = 1'b0;
      out_y_in    = out_y_ff;
      out_last_in = out_last_ff;
      out_dot_in  = out_dot_ff;

      if (accept) begin
         gidx_in = acc_gidx;
         sx_in   = acc_sx;
         sy2_in  = acc_sy2;
         fh_in   = acc_fh;
         ox_in   = is_dot ? dot_x : acc_ox;
         oy_in   = acc_oy;
         attr_in = req_item.attribute;
         cnt_in  = 4'd0;
         if (is_dot && !is_empty) begin
            out_vld_in  = 1'b1;
            out_y_in    = dot_y;
            out_last_in = 1'b1;
            out_dot_in  = 1'b1;
         end
      end

      if (state_ff == ST_FILL) begin
         cnt_in = fill_last ? 4'd0 : cnt_ff + 4'd1;
      end

      if (state_ff == ST_READ) begin
         cnt_in      = cnt_ff + 4'd1;
         out_vld_in  = 1'b1;
         out_y_in    = oy_ff + $signed({8'd0, cnt_ff});
         out_last_in = read_last;
         out_dot_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
         cnt_ff     <= 4'd0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         cnt_ff     <= cnt_in;
      end
      gidx_ff     <= gidx_in;
      sx_ff       <= sx_in;
      sy2_ff      <= sy2_in;
      fh_ff       <= fh_in;
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
      attr_ff     <= attr_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
      out_dot_ff  <= out_dot_in;
   end

   sgr_ram #(
      .WIDTH (9),
      .DEPTH (GLYPH_ROWS)
   ) u_row_buf (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------- result port ----------------
   assign rsp_strobe         = out_vld_ff;
   assign rsp_item.row_y     = out_y_ff;
   assign rsp_item.col_x     = ox_ff;
   assign rsp_item.cell_mask = out_dot_ff ? 9'd3 : ram_rdata;
   assign rsp_item.cell_attr = attr_ff;
   assign rsp_item.last_row  = out_last_ff;

   // ---------------- assertions ----------------
   // a period leaves the block idle, so a glyph may follow it at once
   `ASSERT_IMPLIES(a_no_rsp_in_fill, clock, reset, state_ff == ST_FILL, !rsp_strobe)
   `ASSERT_NEXT(a_last_then_ready, clock, reset,
                rsp_strobe && rsp_item.last_row && !out_dot_ff, !busy)
   `ASSERT_IMPLIES(a_read_in_range, clock, reset, ram_re,
                   ram_raddr < RAM_AW'(GLYPH_ROWS))
   `ASSERT_NEXT(a_read_gives_row, clock, reset, state_ff == ST_READ,
                rsp_strobe && !rsp_item.last_row == (state_ff == ST_READ))

endmodule

`default_nettype wire

// ===== bench/scaled_glyph_row_generator_top_tb.sv =====
// ---------------------------------------------------------------------------
// scaled_glyph_row_generator_top_tb
// Drives characters and target rectangles into the row generator and checks
// each strobed row against rows drawn here from a local font table. A short
// directed table covers empty rectangles, unknown codes, periods, scale
// boundaries and extreme positions. Random characters follow, sent in bursts.
// ---------------------------------------------------------------------------
module scaled_glyph_row_generator_top_tb;
   import sgr_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEM_TARGET = 360;
   localparam int PAUSE_AT = 150;
   localparam int MAX_ROWS = 10;

   typedef enum logic [1:0] {
      ROWS_PREDICTED,
      ROWS_NONE,
      ROW_FIXED
   } row_source_type;

   typedef struct packed {
      sgr_req_type    req;
      row_source_type src;
      sgr_rsp_type    row;
   } stim_entry_type;

   localparam sgr_rsp_type NO_ROW = '0;

   // bit 0 is the leftmost column; digits, then letters
   localparam logic [2:0] font_bitmap [36][5] = '{
      '{3'd7,3'd5,3'd5,3'd5,3'd7}, '{3'd4,3'd4,3'd4,3'd4,3'd4},
      '{3'd7,3'd4,3'd7,3'd1,3'd7}, '{3'd7,3'd4,3'd7,3'd4,3'd7},
      '{3'd5,3'd5,3'd7,3'd4,3'd4}, '{3'd7,3'd1,3'd7,3'd4,3'd7},
      '{3'd7,3'd1,3'd7,3'd5,3'd7}, '{3'd7,3'd4,3'd4,3'd4,3'd4},
      '{3'd7,3'd5,3'd7,3'd5,3'd7}, '{3'd7,3'd5,3'd7,3'd4,3'd7},
      '{3'd2,3'd5,3'd7,3'd5,3'd5}, '{3'd3,3'd5,3'd3,3'd5,3'd3},
      '{3'd7,3'd1,3'd1,3'd1,3'd7}, '{3'd3,3'd5,3'd5,3'd5,3'd3},
      '{3'd7,3'd1,3'd3,3'd1,3'd7}, '{3'd7,3'd1,3'd3,3'd1,3'd1},
      '{3'd7,3'd1,3'd5,3'd5,3'd7}, '{3'd5,3'd5,3'd7,3'd5,3'd5},
      '{3'd7,3'd2,3'd2,3'd2,3'd7}, '{3'd4,3'd4,3'd4,3'd5,3'd7},
      '{3'd5,3'd5,3'd3,3'd5,3'd5}, '{3'd1,3'd1,3'd1,3'd1,3'd7},
      '{3'd7,3'd7,3'd5,3'd5,3'd5}, '{3'd3,3'd5,3'd5,3'd5,3'd5},
      '{3'd7,3'd5,3'd5,3'd5,3'd7}, '{3'd7,3'd5,3'd7,3'd1,3'd1},
      '{3'd7,3'd5,3'd5,3'd7,3'd4}, '{3'd7,3'd5,3'd3,3'd5,3'd5},
      '{3'd7,3'd1,3'd7,3'd4,3'd7}, '{3'd7,3'd2,3'd2,3'd2,3'd2},
      '{3'd5,3'd5,3'd5,3'd5,3'd7}, '{3'd5,3'd5,3'd5,3'd5,3'd2},
      '{3'd5,3'd5,3'd5,3'd7,3'd7}, '{3'd5,3'd5,3'd2,3'd5,3'd5},
      '{3'd5,3'd5,3'd2,3'd2,3'd2}, '{3'd7,3'd4,3'd2,3'd1,3'd7}
   };

   // char, x, y, w, h, attr, source, fixed row
   localparam int NUM_DIRECTED = 24;
   localparam stim_entry_type directed_items [NUM_DIRECTED] = '{
      {CHAR_ZERO, 10'd0, 10'd0, 10'd15, 10'd30, 8'h00, ROWS_PREDICTED, NO_ROW},
      {CHAR_UP_A, 10'd7, 10'd7, 10'd0, 10'd10, 8'h11, ROWS_NONE, NO_ROW},
      {CHAR_UP_Z, 10'd7, 10'd7, 10'd10, 10'd0, 8'h22, ROWS_NONE, NO_ROW},
      {CHAR_DOT, 10'd5, 10'd5, 10'd0, 10'd5, 8'h33, ROWS_NONE, NO_ROW},
      {CHAR_DOT, 10'd100, 10'd200, 10'd10, 10'd10, 8'h5A, ROW_FIXED,
       {12'd208, 12'd104, 9'd3, 8'h5A, 1'b1}},
      {CHAR_DOT, 10'd0, 10'd0, 10'd1, 10'd1, 8'h00, ROW_FIXED,
       {12'hFFF, 12'd0, 9'd3, 8'h00, 1'b1}},
      {CHAR_DOT, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'hFF, ROW_FIXED,
       {12'd2044, 12'd1533, 9'd3, 8'hFF, 1'b1}},
      {CHAR_DOT, 10'd0, 10'd0, 10'd2, 10'd1023, 8'h81, ROW_FIXED,
       {12'd1021, 12'd0, 9'd3, 8'h81, 1'b1}},
      {8'h00, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'hFF, ROWS_NONE, NO_ROW},
      {8'hFF, 10'd1, 10'd1, 10'd20, 10'd20, 8'h01, ROWS_NONE, NO_ROW},
      {8'h2F, 10'd1, 10'd1, 10'd20, 10'd20, 8'h02, ROWS_NONE, NO_ROW},
      {8'h3A, 10'd1, 10'd1, 10'd20, 10'd20, 8'h04, ROWS_NONE, NO_ROW},
      {8'h40, 10'd1, 10'd1, 10'd20, 10'd20, 8'h08, ROWS_NONE, NO_ROW},
      {8'h5B, 10'd1, 10'd1, 10'd20, 10'd20, 8'h10, ROWS_NONE, NO_ROW},
      {8'h60, 10'd1, 10'd1, 10'd20, 10'd20, 8'h20, ROWS_NONE, NO_ROW},
      {8'h7B, 10'd1, 10'd1, 10'd20, 10'd20, 8'h40, ROWS_NONE, NO_ROW},
      {CHAR_NINE, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'hAA, ROWS_PREDICTED,
       NO_ROW},
      {CHAR_UP_A, 10'd0, 10'd0, 10'd1, 10'd1, 8'h55, ROWS_PREDICTED, NO_ROW},
      {CHAR_UP_Z, 10'd5, 10'd5, 10'd5, 10'd6, 8'h3C, ROWS_PREDICTED, NO_ROW},
      {CHAR_LO_A, 10'd10, 10'd10, 10'd9, 10'd11, 8'hC3, ROWS_PREDICTED, NO_ROW},
      {CHAR_LO_Z, 10'd10, 10'd10, 10'd10, 10'd12, 8'h0F, ROWS_PREDICTED, NO_ROW},
      {8'h4D, 10'd0, 10'd0, 10'd15, 10'd12, 8'hF0, ROWS_PREDICTED, NO_ROW},
      {8'h71, 10'd300, 10'd40, 10'd4, 10'd3, 8'h99, ROWS_PREDICTED, NO_ROW},
      {8'h38, 10'd512, 10'd512, 10'd1023, 10'd7, 8'h66, ROWS_PREDICTED, NO_ROW}
   };

   logic           clock;
   logic           reset;
   logic           start;
   logic           busy;
   sgr_req_type    req_item;
   logic           rsp_strobe;
   sgr_rsp_type    rsp_item;

   row_source_type cur_src;
   sgr_rsp_type    cur_fixed;
   sgr_rsp_type    pending_rows [$];
   int             fail_count;
   int             cycle_count;

   scaled_glyph_row_generator_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // rows of one character, top first; returns the row count
   function automatic int draw_glyph_rows(input sgr_req_type r,
                                          output sgr_rsp_type rows [MAX_ROWS]);
      int         rx, ry, rw, rh;
      int         code, idx;
      int         sx, sy, fw, fh, ox, oy;
      logic [2:0] bits;
      logic [8:0] mask;
      rows = '{default: '0};
      rx = int'(r.rect_x);
      ry = int'(r.rect_y);
      rw = int'(r.rect_w);
      rh = int'(r.rect_h);
      code = int'(r.char_code);
      if (rw == 0 || rh == 0) return 0;
      if (r.char_code == CHAR_DOT) begin
         rows[0].row_y = 12'(ry + rh - 2);
         rows[0].col_x = 12'(rx + (rw - 2) / 2);
         rows[0].cell_mask = 9'd3;
         rows[0].cell_attr = r.attribute;
         rows[0].last_row = 1'b1;
         return 1;
      end
      if (code >= int'(CHAR_ZERO) && code <= int'(CHAR_NINE))
         idx = code - int'(CHAR_ZERO);
      else if (code >= int'(CHAR_UP_A) && code <= int'(CHAR_UP_Z))
         idx = 10 + code - int'(CHAR_UP_A);
      else if (code >= int'(CHAR_LO_A) && code <= int'(CHAR_LO_Z))
         idx = 10 + code - int'(CHAR_LO_A);
      else
         return 0;
      sx = rw / (GLYPH_COLS + 2);
      if (sx < 1) sx = 1;
      if (sx > 3) sx = 3;
      sy = rh / (GLYPH_ROWS + 1);
      if (sy < 1) sy = 1;
      if (sy > 2) sy = 2;
      fw = GLYPH_COLS * sx;
      fh = GLYPH_ROWS * sy;
      // int division truncates toward zero, also for small rectangles
      ox = rx + (rw - fw) / 2;
      oy = ry + (rh - fh) / 2;
      for (int row = 0; row < fh; row++) begin
         bits = font_bitmap[idx][row / sy];
         mask = '0;
         for (int c = 0; c < fw; c++)
            if (bits[c / sx]) mask[c] = 1'b1;
         rows[row].row_y = 12'(oy + row);
         rows[row].col_x = 12'(ox);
         rows[row].cell_mask = mask;
         rows[row].cell_attr = r.attribute;
         rows[row].last_row = (row == fh - 1);
      end
      return fh;
   endfunction

   function automatic sgr_req_type random_request();
      sgr_req_type r;
      int          pick;
      int          g;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         g = $urandom_range(0, 35);
         if (g < 10)
            r.char_code = CHAR_ZERO + 8'(g);
         else if ($urandom_range(0, 1) == 1)
            r.char_code = CHAR_LO_A + 8'(g - 10);
         else
            r.char_code = CHAR_UP_A + 8'(g - 10);
      end else if (pick < 82) begin
         r.char_code = CHAR_DOT;
      end else begin
         r.char_code = 8'($urandom);
      end
      r.rect_x = 10'($urandom);
      r.rect_y = 10'($urandom);
      // mostly small rectangles around the scale steps, some anywhere
      if ($urandom_range(0, 4) != 0) begin
         r.rect_w = 10'($urandom_range(0, 20));
         r.rect_h = 10'($urandom_range(0, 16));
      end else begin
         r.rect_w = 10'($urandom);
         r.rect_h = 10'($urandom);
      end
      r.attribute = 8'($urandom);
      return r;
   endfunction

   task automatic send_char(input sgr_req_type r, input row_source_type src,
                            input sgr_rsp_type fixed);
      req_item <= r;
      cur_src <= src;
      cur_fixed <= fixed;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // predict on each transfer, check each strobed row
   always @(posedge clock) begin
      sgr_rsp_type drawn [MAX_ROWS];
      sgr_rsp_type want;
      int          n;
      if (!reset) begin
         if (start && !busy) begin
            case (cur_src)
               ROW_FIXED: pending_rows.push_back(cur_fixed);
               ROWS_PREDICTED: begin
                  n = draw_glyph_rows(req_item, drawn);
                  for (int k = 0; k < n; k++) pending_rows.push_back(drawn[k]);
               end
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (pending_rows.size() == 0) begin
               if (fail_count < 40)
                  $display("%0t: unexpected row, expected none,", $time,
                           " got y=%0d x=%0d mask=%03h attr=%02h last=%0d",
                           rsp_item.row_y, rsp_item.col_x, rsp_item.cell_mask,
                           rsp_item.cell_attr, rsp_item.last_row);
               fail_count++;
            end else begin
               want = pending_rows.pop_front();
               if (rsp_item.row_y !== want.row_y || rsp_item.col_x !== want.col_x ||
                   rsp_item.cell_mask !== want.cell_mask ||
                   rsp_item.cell_attr !== want.cell_attr ||
                   rsp_item.last_row !== want.last_row) begin
                  if (fail_count < 40)
                     $display("%0t: row mismatch,", $time,
                              " expected y=%0d x=%0d mask=%03h attr=%02h last=%0d,",
                              want.row_y, want.col_x, want.cell_mask,
                              want.cell_attr, want.last_row,
                              " got y=%0d x=%0d mask=%03h attr=%02h last=%0d",
                              rsp_item.row_y, rsp_item.col_x, rsp_item.cell_mask,
                              rsp_item.cell_attr, rsp_item.last_row);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      sgr_req_type r;
      int          sent_count;
      int          burst_left;
      int          gap;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      cur_src = ROWS_NONE;
      cur_fixed = '0;
      fail_count = 0;
      cycle_count = 0;
      sent_count = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_char(directed_items[i].req, directed_items[i].src, directed_items[i].row);
         sent_count++;
         if ($urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end

      burst_left = $urandom_range(1, 16);
      while (sent_count < ITEM_TARGET) begin
         r = random_request();
         send_char(r, ROWS_PREDICTED, NO_ROW);
         sent_count++;
         if (sent_count == PAUSE_AT) begin
            // hold off until every row in flight has come back
            start <= 1'b0;
            @(posedge clock);
            wait (pending_rows.size() == 0);
            @(posedge clock);
         end else if (--burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            // some bursts run back to back, others leave a gap
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end

      start <= 1'b0;
      @(posedge clock);
      wait (pending_rows.size() == 0);
      repeat (30) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
